// File: rtl/qiwl_pkg.sv
// shared types, constants and edge tables for the quad index to wireframe converter
package qiwl_pkg;

    localparam int INDEX_BITS = 32;
    localparam int FIELD_BITS = 32;
    localparam int GROUP_QUAD = 6;
    localparam int GROUP_TRI  = 3;
    localparam int Q_DEPTH    = 2;
    localparam int FILL_BITS  = $clog2(GROUP_QUAD);
    localparam int STEP_BITS  = 4;
    localparam int QPTR_BITS  = $clog2(Q_DEPTH);
    localparam int QCNT_BITS  = $clog2(Q_DEPTH + 1);

    typedef logic [INDEX_BITS-1:0] t_idx;

    typedef struct packed {
        logic [FIELD_BITS-1:0] vertex_index;
        logic                  list_end;
    } t_in;

    typedef struct packed {
        logic [FIELD_BITS-1:0] line_index;
        logic                  index_valid;
        logic                  run_last;
    } t_out;

    typedef enum logic [1:0] {
        KIND_EMPTY   = 2'd0,
        KIND_TRI     = 2'd1,
        KIND_TWO_TRI = 2'd2,
        KIND_QUAD    = 2'd3
    } t_kind;

    // one unit of work for the back end: a gathered group and how to outline it
    typedef struct packed {
        t_idx [GROUP_QUAD-1:0] slots;
        t_kind                 kind;
        logic                  last;
    } t_job;

    function automatic logic [STEP_BITS-1:0] job_len(input t_kind kind);
        logic [STEP_BITS-1:0] len;
        case (kind)
            KIND_EMPTY:   len = STEP_BITS'(1);
            KIND_TRI:     len = STEP_BITS'(6);
            KIND_TWO_TRI: len = STEP_BITS'(12);
            KIND_QUAD:    len = STEP_BITS'(8);
            default:      len = STEP_BITS'(1);
        endcase
        return len;
    endfunction

    // which gathered slot feeds a given output position
    function automatic logic [FILL_BITS-1:0] slot_sel(input t_kind kind,
                                                       input logic [STEP_BITS-1:0] step);
        logic [FILL_BITS-1:0] s;
        s = '0;
        case (kind)
            KIND_QUAD: begin
                case (step)
                    4'd1, 4'd2: s = 3'd1;
                    4'd3, 4'd4: s = 3'd2;
                    4'd5, 4'd6: s = 3'd4;
                    default:    s = 3'd0;
                endcase
            end
            KIND_TRI, KIND_TWO_TRI: begin
                case (step)
                    4'd1, 4'd2:  s = 3'd1;
                    4'd3, 4'd4:  s = 3'd2;
                    4'd6, 4'd11: s = 3'd3;
                    4'd7, 4'd8:  s = 3'd4;
                    4'd9, 4'd10: s = 3'd5;
                    default:     s = 3'd0;
                endcase
            end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/qiwl_front.sv
// front end: gathers indices into groups, detects grid quads, issues jobs
module qiwl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qiwl_pkg::t_in i_in,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output qiwl_pkg::t_job o_job
);
    import qiwl_pkg::*;

    t_idx [GROUP_QUAD-1:0]  r_grp;
    logic [FILL_BITS-1:0]   r_fill;
    logic                   r_tri;
    logic [FILL_BITS-1:0]   n_fill;
    logic                   n_tri;

    t_idx                   v;
    t_idx [GROUP_QUAD-1:0]  slots;
    logic [FILL_BITS-1:0]   cnt;
    logic                   grid;
    logic                   emit;
    t_kind                  kind;
    logic                   accept;

    assign o_in_ready = i_job_ready;
    assign accept     = i_in_valid && i_job_ready;
    assign v          = t_idx'(i_in.vertex_index);

    always_comb begin
        slots        = r_grp;
        slots[r_fill] = v;
        cnt          = r_fill + FILL_BITS'(1);
        grid = (slots[1] == slots[0] + t_idx'(1)) && (slots[3] == slots[2]) &&
               (slots[4] == slots[3] - t_idx'(1)) && (slots[5] == slots[0]);
        emit   = 1'b0;
        kind   = KIND_EMPTY;
        n_fill = cnt;
        n_tri  = r_tri;
        if (r_tri) begin
            if (cnt == FILL_BITS'(GROUP_TRI)) begin
                emit   = 1'b1;
                kind   = KIND_TRI;
                n_fill = '0;
            end
        end else if (32'(cnt) == 32'(GROUP_QUAD)) begin
            emit   = 1'b1;
            kind   = grid ? KIND_QUAD : KIND_TWO_TRI;
            n_tri  = !grid;
            n_fill = '0;
        end
        if (i_in.list_end) begin
            // partial quad group of three to five yields one triangle
            if (!emit && n_fill >= FILL_BITS'(GROUP_TRI)) begin
                kind = KIND_TRI;
            end
            emit   = 1'b1;
            n_fill = '0;
            n_tri  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_tri  <= 1'b0;
        end else if (accept) begin
            r_fill <= n_fill;
            r_tri  <= n_tri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grp[r_fill] <= v;
        end
    end

    assign o_job_valid = accept && emit;
    assign o_job.slots = slots;
    assign o_job.kind  = kind;
    assign o_job.last  = i_in.list_end;

endmodule

// File: rtl/qiwl_queue.sv
// short job queue between front and back ends
module qiwl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qiwl_pkg::t_job i_job,
    output logic           o_not_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output qiwl_pkg::t_job o_head
);
    import qiwl_pkg::*;

    t_job                 r_mem [Q_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_not_full   = r_cnt != QCNT_BITS'(Q_DEPTH);
    assign o_head_valid = r_cnt != '0;
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && o_not_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_BITS'(1);
            end
            r_cnt <= r_cnt + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: rtl/qiwl_back.sv
// back end: walks job edge tables, one line index per cycle unless stalled
module qiwl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  qiwl_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output qiwl_pkg::t_out o_out
);
    import qiwl_pkg::*;

    logic [STEP_BITS-1:0] r_step;
    logic                 r_out_valid;
    t_out                 r_out;
    logic [STEP_BITS-1:0] len;
    logic                 final_step;
    logic                 load;
    t_out                 n_out;

    assign len        = job_len(i_job.kind);
    assign final_step = r_step == len - STEP_BITS'(1);
    assign load       = i_job_valid && (!r_out_valid || i_out_ready);
    assign o_pop      = load && final_step;

    always_comb begin
        n_out.line_index  = FIELD_BITS'(i_job.slots[slot_sel(i_job.kind, r_step)]);
        n_out.index_valid = 1'b1;
        n_out.run_last    = i_job.last && final_step;
        if (i_job.kind == KIND_EMPTY) begin
            n_out.line_index  = '0;
            n_out.index_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step <= final_step ? '0 : r_step + STEP_BITS'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> r_step < len)
        else $error("edge step past end of job");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.index_valid |-> r_out.run_last)
        else $error("bare end marker without run_last");

    a_pop_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out.run_last == $past(i_job.last))
        else $error("run_last does not follow list end of finished job");

endmodule

// File: rtl/quad_index_to_wireframe_lines.sv
// top level of the quad-aware triangle index to wireframe line converter
// a group's closing index transfer queues a job; the back end registers its first line index
// one line index per cycle unless stalled; a grid quad gives 8 line indices, a triangle 6
// input is taken while the two-entry job queue has room, set by the single output port
// reset: synchronous active low, clears fill count, mode, queue pointers and output valid
// group store holds no reset value and is only read where written in the current group
module quad_index_to_wireframe_lines (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  qiwl_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output qiwl_pkg::t_out  o_out
);
    import qiwl_pkg::*;

    logic job_valid;
    logic q_not_full;
    t_job job;
    logic head_valid;
    t_job head;
    logic pop;

    qiwl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_job_valid (job_valid),
        .i_job_ready (q_not_full),
        .o_job       (job)
    );

    qiwl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (job_valid),
        .i_job        (job),
        .o_not_full   (q_not_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    qiwl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: test/tb_top.sv
// self-checking testbench for the quad index to wireframe line converter
`timescale 1ns / 100ps

module tb_top;
    import qiwl_pkg::*;

    localparam int RAND_ITEMS     = 450;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 16;
    localparam int DIR_N          = 24;

    typedef struct packed {
        bit                    typed;
        logic [FIELD_BITS-1:0] vertex;
        bit                    fin;
        t_out                  exp;
    } t_row;

    localparam t_out END_MARK = '{line_index: '0, index_valid: 1'b0, run_last: 1'b1};
    localparam t_out NO_EXP   = '0;

    // directed lists; typed rows carry the bare end marker the block must give
    localparam t_row DIR_ROWS [DIR_N] = '{
        '{1'b1, 32'h0000_0000, 1'b1, END_MARK},  // lone index right after reset
        '{1'b1, 32'hFFFF_FFFF, 1'b1, END_MARK},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, NO_EXP},    // grid quad wrapping through zero
        '{1'b0, 32'h0000_0000, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0005, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0005, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0004, 1'b0, NO_EXP},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, NO_EXP},
        '{1'b1, 32'h0000_0007, 1'b1, END_MARK},  // single leftover dropped
        '{1'b0, 32'h0000_0001, 1'b0, NO_EXP},    // broken quad falls back to triangles
        '{1'b0, 32'h0000_0002, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0003, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0004, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0005, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0006, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0007, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0008, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0009, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_000A, 1'b0, NO_EXP},
        '{1'b1, 32'h0000_000B, 1'b1, END_MARK},  // two leftovers in triangle mode
        '{1'b0, 32'h0000_0020, 1'b0, NO_EXP},    // back in quad mode, partial group
        '{1'b0, 32'h0000_0021, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0022, 1'b0, NO_EXP},
        '{1'b0, 32'h0000_0023, 1'b1, NO_EXP}
    };

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in        = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    // predictor state
    t_idx grp [GROUP_QUAD];
    int   grp_fill = 0;
    bit   tri_mode = 1'b0;

    t_out step_lines [$];
    t_out lines_due [$];
    t_in  list_buf [$];
    t_out due_line;

    bit in_gaps    = 1'b1;
    bit draining   = 1'b0;
    int stall_left = 0;
    int ready_mode = 0;
    int mode_left  = 0;
    int ready_roll;
    bit ready_next;

    int quiet_cycles = 0;
    int errors       = 0;
    int in_cnt       = 0;
    int out_cnt      = 0;
    int list_cnt     = 0;
    int quad_cnt     = 0;
    int split_cnt    = 0;

    quad_index_to_wireframe_lines i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void add_edge(input t_idx a, input t_idx b);
        t_out ln;
        ln.index_valid = 1'b1;
        ln.run_last    = 1'b0;
        ln.line_index  = FIELD_BITS'(a);
        step_lines     = {step_lines, ln};
        ln.line_index  = FIELD_BITS'(b);
        step_lines     = {step_lines, ln};
    endfunction

    function automatic void add_triangle(input t_idx a, input t_idx b, input t_idx c);
        add_edge(a, b);
        add_edge(b, c);
        add_edge(c, a);
    endfunction

    // line indices caused by one index transfer, left in step_lines
    function automatic void outline_index(input t_in item);
        t_out tail;
        step_lines.delete();
        if (grp_fill >= GROUP_QUAD)
            grp_fill = 0;
        grp[grp_fill] = item.vertex_index[INDEX_BITS-1:0];
        grp_fill++;
        if (!tri_mode) begin
            if (grp_fill == GROUP_QUAD) begin
                if (grp[1] == grp[0] + t_idx'(1) && grp[3] == grp[2] &&
                    grp[4] == grp[3] - t_idx'(1) && grp[5] == grp[0]) begin
                    add_edge(grp[0], grp[1]);
                    add_edge(grp[1], grp[2]);
                    add_edge(grp[2], grp[4]);
                    add_edge(grp[4], grp[0]);
                    quad_cnt++;
                end else begin
                    add_triangle(grp[0], grp[1], grp[2]);
                    add_triangle(grp[3], grp[4], grp[5]);
                    tri_mode = 1'b1;
                    split_cnt++;
                end
                grp_fill = 0;
            end
        end else if (grp_fill >= GROUP_TRI) begin
            add_triangle(grp[0], grp[1], grp[2]);
            grp_fill = 0;
        end
        if (item.list_end) begin
            if (grp_fill >= GROUP_TRI)
                add_triangle(grp[0], grp[1], grp[2]);
            if (step_lines.size() == 0) begin
                tail = '0;
                step_lines = {step_lines, tail};
            end
            tail = step_lines.pop_back();
            tail.run_last = 1'b1;
            step_lines = {step_lines, tail};
            grp_fill = 0;
            tri_mode = 1'b0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!in_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_idx rand_index();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return t_idx'($urandom_range(0, 15));
            3: return '1 - t_idx'($urandom_range(0, 15));
            default: return t_idx'($urandom);
        endcase
    endfunction

    function automatic void queue_index(input t_idx v);
        t_in item;
        item.vertex_index = FIELD_BITS'(v);
        item.list_end     = 1'b0;
        list_buf          = {list_buf, item};
    endfunction

    // grid quad, optionally with one slot knocked out of shape
    function automatic void queue_quad(input bit broken);
        t_idx q [GROUP_QUAD];
        int   s;
        q[0] = rand_index();
        q[1] = q[0] + t_idx'(1);
        q[2] = rand_index();
        q[3] = q[2];
        q[4] = q[2] - t_idx'(1);
        q[5] = q[0];
        if (broken) begin
            s = $urandom_range(1, 5);
            q[s] = q[s] ^ (t_idx'(1) << $urandom_range(0, INDEX_BITS - 1));
        end
        for (int k = 0; k < GROUP_QUAD; k++)
            queue_index(q[k]);
    endfunction

    task automatic send_index(input t_in item, input bit typed, input t_out typed_exp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        in_cnt++;
        outline_index(item);
        if (typed)
            lines_due = {lines_due, typed_exp};
        else
            foreach (step_lines[k])
                lines_due = {lines_due, step_lines[k]};
    endtask

    initial begin
        t_in item;
        int  rnd_items;
        int  kind;
        int  n;
        rnd_items = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_N; r++) begin
            item.vertex_index = DIR_ROWS[r].vertex;
            item.list_end     = DIR_ROWS[r].fin;
            send_index(item, DIR_ROWS[r].typed, DIR_ROWS[r].exp);
            if (item.list_end)
                list_cnt++;
        end

        while (rnd_items < RAND_ITEMS) begin
            list_buf.delete();
            in_gaps = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise list
                n = $urandom_range(1, 14);
                repeat (n) queue_index(rand_index());
            end else begin
                n = $urandom_range(0, 4);
                repeat (n) begin
                    case ($urandom_range(0, 7))
                        0: queue_quad(1'b1);
                        1: repeat (GROUP_QUAD) queue_index(rand_index());
                        default: queue_quad(1'b0);
                    endcase
                end
                n = 3 * $urandom_range(0, 3);
                repeat (n) queue_index(rand_index());
                n = $urandom_range(0, 5);
                repeat (n) queue_index(rand_index());
            end
            if (list_buf.size() == 0)
                queue_index(rand_index());
            item = list_buf.pop_back();
            item.list_end = 1'b1;
            list_buf = {list_buf, item};
            foreach (list_buf[k])
                send_index(list_buf[k], 1'b0, NO_EXP);
            rnd_items += list_buf.size();
            list_cnt++;
        end
        i_in_valid <= 1'b0;

        while (lines_due.size() != 0)
            @(posedge i_clk);
        draining = 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d lists: %0d index transfers in, %0d line transfers out",
                 list_cnt, in_cnt, out_cnt);
        $display("%0d grid quads outlined, %0d groups fell back to triangles, %0d errors",
                 quad_cnt, split_cnt, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // output back-pressure: modes switch every so often, some stretches never stall
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        ready_roll = $urandom_range(0, 99);
        if (draining) begin
            ready_next = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else if (ready_mode == 0) begin
            ready_next = 1'b1;
        end else if (ready_roll < 3) begin
            stall_left = $urandom_range(8, 50);
            ready_next = 1'b0;
        end else begin
            ready_next = (ready_roll >= (ready_mode == 1 ? 25 : 50));
        end
        i_out_ready <= ready_next;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_cnt++;
            if (lines_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected line transfer, actual index %h valid %b last %b",
                         $time, o_out.line_index, o_out.index_valid, o_out.run_last);
            end else begin
                due_line = lines_due.pop_front();
                if (o_out.line_index !== due_line.line_index ||
                    o_out.index_valid !== due_line.index_valid ||
                    o_out.run_last !== due_line.run_last) begin
                    errors++;
                    $display("%0t: expected index %h valid %b last %b, actual %h %b %b",
                             $time, due_line.line_index, due_line.index_valid,
                             due_line.run_last, o_out.line_index, o_out.index_valid,
                             o_out.run_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
